>>> hw/rtl/lcdsr_pkg.sv
// Package for the LCD control/status register block.
// Holds the command and result word types, command codes and register addresses.
// No dependencies.
package lcdsr_pkg;

    // Command codes; codes 5 to 7 are unused and change nothing
    localparam logic [2:0] CMD_READ      = 3'd0;
    localparam logic [2:0] CMD_WRITE     = 3'd1;
    localparam logic [2:0] CMD_NEXT_LINE = 3'd2;
    localparam logic [2:0] CMD_SET_MODE  = 3'd3;
    localparam logic [2:0] CMD_NEW_FRAME = 3'd4;

    // Register addresses (low byte)
    localparam logic [7:0] ADDR_LCDC = 8'h40;
    localparam logic [7:0] ADDR_STAT = 8'h41;
    localparam logic [7:0] ADDR_SCY  = 8'h42;
    localparam logic [7:0] ADDR_SCX  = 8'h43;
    localparam logic [7:0] ADDR_LY   = 8'h44;
    localparam logic [7:0] ADDR_LYC  = 8'h45;
    localparam logic [7:0] ADDR_BGP  = 8'h47;
    localparam logic [7:0] ADDR_OBP0 = 8'h48;
    localparam logic [7:0] ADDR_OBP1 = 8'h49;
    localparam logic [7:0] ADDR_WY   = 8'h4A;
    localparam logic [7:0] ADDR_WX   = 8'h4B;
    localparam logic [7:0] ADDR_OPRI = 8'h6C;

    // Boot values
    localparam logic [7:0] LCDC_RESET = 8'h91;
    localparam logic [7:0] STAT_RESET = 8'h85;
    localparam logic [7:0] BGP_RESET  = 8'hFC;
    localparam logic [7:0] OBP_RESET  = 8'hFF;

    localparam logic [7:0] READ_IDLE    = 8'hFF;
    localparam logic [7:0] OPRI_PATTERN = 8'hFE;

    localparam logic [1:0] MODE_OAM_SCAN = 2'd2;

    localparam logic [15:0] MAP_HIGH   = 16'h9C00;
    localparam logic [15:0] MAP_LOW    = 16'h9800;
    localparam logic [15:0] TILES_LOW  = 16'h8000;
    localparam logic [15:0] TILES_HIGH = 16'h8800;

    localparam logic [4:0] SPRITE_TALL  = 5'd16;
    localparam logic [4:0] SPRITE_SHORT = 5'd8;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] address;
        logic [7:0] write_data;
        logic [1:0] new_mode;
        logic [1:0] bg_color_index;
        logic       sprite_palette_select;
        logic [1:0] sprite_color_index;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        stat_interrupt;
        logic [7:0]  scanline;
        logic [1:0]  lcd_mode;
        logic [1:0]  bg_shade;
        logic [1:0]  sprite_shade;
        logic [4:0]  sprite_height;
        logic [15:0] window_map_base;
        logic [15:0] tile_data_base;
        logic [15:0] bg_map_base;
        logic [3:0]  enable_flags;
        logic        priority_mode;
    } rsp_t;

    // Pick the 2-bit shade for a colour index out of a palette byte
    function automatic logic [1:0] shade_of(input logic [7:0] pal, input logic [1:0] idx);
        logic [1:0] s;
        unique case (idx)
            2'd0:    s = pal[1:0];
            2'd1:    s = pal[3:2];
            2'd2:    s = pal[5:4];
            default: s = pal[7:6];
        endcase
        return s;
    endfunction

endpackage

>>> hw/rtl/lcdsr_in_stage.sv
// Input register of the LCD control/status register block.
// Holds one command word until the execute step takes it. Uses lcdsr_pkg.
module lcdsr_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  lcdsr_pkg::cmd_t cmd,
    input  logic            take,
    output logic            item_valid,
    output lcdsr_pkg::cmd_t item
);

    logic            valid_reg;
    logic            valid_next;
    lcdsr_pkg::cmd_t item_reg;
    logic            load;

    // Stall only while a held word cannot move on this cycle
    assign cmd_stall = valid_reg && !take;
    assign load      = cmd_valid && !cmd_stall;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= cmd;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> hw/rtl/lcdsr_regfile.sv
// Register file and command execution of the LCD control/status register block.
// Updates the registers for one command and forms its result word. Uses lcdsr_pkg.
module lcdsr_regfile (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            exec,
    input  lcdsr_pkg::cmd_t item,
    output lcdsr_pkg::rsp_t result
);

    logic [7:0] control_reg, control_next;
    logic [7:0] status_reg, status_next;
    logic [7:0] scroll_y_reg, scroll_y_next;
    logic [7:0] scroll_x_reg, scroll_x_next;
    logic [7:0] line_reg, line_next;
    logic [7:0] compare_reg, compare_next;
    logic [7:0] bgp_reg, bgp_next;
    logic [7:0] obp0_reg, obp0_next;
    logic [7:0] obp1_reg, obp1_next;
    logic [7:0] win_y_reg, win_y_next;
    logic [7:0] win_x_reg, win_x_next;
    logic       pri_reg, pri_next;

    logic [7:0] read_data;
    logic [7:0] line_inc;
    logic       hit;
    logic       irq;

    assign line_inc = line_reg + 8'd1;
    assign hit      = (line_inc == compare_reg);

    always_comb
    begin
        unique case (item.address)
            lcdsr_pkg::ADDR_LCDC: read_data = control_reg;
            lcdsr_pkg::ADDR_STAT: read_data = status_reg;
            lcdsr_pkg::ADDR_SCY:  read_data = scroll_y_reg;
            lcdsr_pkg::ADDR_SCX:  read_data = scroll_x_reg;
            lcdsr_pkg::ADDR_LY:   read_data = line_reg;
            lcdsr_pkg::ADDR_LYC:  read_data = compare_reg;
            lcdsr_pkg::ADDR_BGP:  read_data = bgp_reg;
            lcdsr_pkg::ADDR_OBP0: read_data = obp0_reg;
            lcdsr_pkg::ADDR_OBP1: read_data = obp1_reg;
            lcdsr_pkg::ADDR_WY:   read_data = win_y_reg;
            lcdsr_pkg::ADDR_WX:   read_data = win_x_reg;
            lcdsr_pkg::ADDR_OPRI: read_data = lcdsr_pkg::OPRI_PATTERN | {7'd0, pri_reg};
            default:              read_data = lcdsr_pkg::READ_IDLE;
        endcase
    end

    always_comb
    begin
        control_next  = control_reg;
        status_next   = status_reg;
        scroll_y_next = scroll_y_reg;
        scroll_x_next = scroll_x_reg;
        line_next     = line_reg;
        compare_next  = compare_reg;
        bgp_next      = bgp_reg;
        obp0_next     = obp0_reg;
        obp1_next     = obp1_reg;
        win_y_next    = win_y_reg;
        win_x_next    = win_x_reg;
        pri_next      = pri_reg;
        irq           = 1'b0;
        unique case (item.command)
            lcdsr_pkg::CMD_WRITE:
            begin
                // LY and unknown addresses drop the write
                unique case (item.address)
                    lcdsr_pkg::ADDR_LCDC: control_next  = item.write_data;
                    lcdsr_pkg::ADDR_STAT: status_next   = item.write_data;
                    lcdsr_pkg::ADDR_SCY:  scroll_y_next = item.write_data;
                    lcdsr_pkg::ADDR_SCX:  scroll_x_next = item.write_data;
                    lcdsr_pkg::ADDR_LYC:  compare_next  = item.write_data;
                    lcdsr_pkg::ADDR_BGP:  bgp_next      = item.write_data;
                    lcdsr_pkg::ADDR_OBP0: obp0_next     = item.write_data;
                    lcdsr_pkg::ADDR_OBP1: obp1_next     = item.write_data;
                    lcdsr_pkg::ADDR_WY:   win_y_next    = item.write_data;
                    lcdsr_pkg::ADDR_WX:   win_x_next    = item.write_data;
                    lcdsr_pkg::ADDR_OPRI: pri_next      = item.write_data[0];
                    default:              ;
                endcase
            end
            lcdsr_pkg::CMD_NEXT_LINE:
            begin
                line_next      = line_inc;
                status_next[2] = hit;
                irq            = hit && status_reg[6];
            end
            lcdsr_pkg::CMD_SET_MODE:
            begin
                status_next[1:0] = item.new_mode;
            end
            lcdsr_pkg::CMD_NEW_FRAME:
            begin
                status_next[1:0] = lcdsr_pkg::MODE_OAM_SCAN;
                line_next        = 8'd0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg  <= lcdsr_pkg::LCDC_RESET;
            status_reg   <= lcdsr_pkg::STAT_RESET;
            scroll_y_reg <= 8'd0;
            scroll_x_reg <= 8'd0;
            line_reg     <= 8'd0;
            compare_reg  <= 8'd0;
            bgp_reg      <= lcdsr_pkg::BGP_RESET;
            obp0_reg     <= lcdsr_pkg::OBP_RESET;
            obp1_reg     <= lcdsr_pkg::OBP_RESET;
            win_y_reg    <= 8'd0;
            win_x_reg    <= 8'd0;
            pri_reg      <= 1'b0;
        end
        else if (exec)
        begin
            control_reg  <= control_next;
            status_reg   <= status_next;
            scroll_y_reg <= scroll_y_next;
            scroll_x_reg <= scroll_x_next;
            line_reg     <= line_next;
            compare_reg  <= compare_next;
            bgp_reg      <= bgp_next;
            obp0_reg     <= obp0_next;
            obp1_reg     <= obp1_next;
            win_y_reg    <= win_y_next;
            win_x_reg    <= win_x_next;
            pri_reg      <= pri_next;
        end
    end

    // Result word reflects the registers after the command
    always_comb
    begin
        result.read_data      = (item.command == lcdsr_pkg::CMD_READ) ? read_data
                                                                      : lcdsr_pkg::READ_IDLE;
        result.stat_interrupt = irq;
        result.scanline       = line_next;
        result.lcd_mode       = status_next[1:0];
        result.bg_shade       = lcdsr_pkg::shade_of(bgp_next, item.bg_color_index);
        result.sprite_shade   = lcdsr_pkg::shade_of(item.sprite_palette_select ? obp1_next
                                                                               : obp0_next,
                                                    item.sprite_color_index);
        result.sprite_height  = control_next[2] ? lcdsr_pkg::SPRITE_TALL
                                                : lcdsr_pkg::SPRITE_SHORT;
        result.window_map_base = control_next[6] ? lcdsr_pkg::MAP_HIGH : lcdsr_pkg::MAP_LOW;
        result.tile_data_base  = control_next[4] ? lcdsr_pkg::TILES_LOW
                                                 : lcdsr_pkg::TILES_HIGH;
        result.bg_map_base     = control_next[3] ? lcdsr_pkg::MAP_HIGH : lcdsr_pkg::MAP_LOW;
        result.enable_flags    = {control_next[7], control_next[5],
                                  control_next[1], control_next[0]};
        result.priority_mode   = pri_next;
    end

endmodule

>>> hw/rtl/lcdsr_out_stage.sv
// Result register of the LCD control/status register block.
// Holds one result word until the consumer takes it. Uses lcdsr_pkg.
module lcdsr_out_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  lcdsr_pkg::rsp_t result,
    output logic            free,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output lcdsr_pkg::rsp_t rsp
);

    logic            valid_reg;
    logic            valid_next;
    lcdsr_pkg::rsp_t rsp_reg;

    // Room for a new word when empty or when the held word leaves this cycle
    assign free = !valid_reg || !rsp_stall;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> hw/rtl/lcd_control_status_registers_unit.sv
// Top level of the LCD control/status register block.
// Ties input register, register file and result register; uses lcdsr_pkg and the lcdsr_* modules.
//
//  channel  | handshake            | word
//  ---------+----------------------+-------------------------------
//  command  | cmd_valid, cmd_stall | cmd (lcdsr_pkg::cmd_t)
//  result   | rsp_valid, rsp_stall | rsp (lcdsr_pkg::rsp_t)
//
// One word per cycle sustained while rsp_stall stays low; a taken command is registered in the
// input register, and the register file executes it from there into the result register,
// where it is held as a valid result until the consumer takes it.
// Reset loads the boot register values and empties both stages.
// A stalled result holds the execute step, and the input register then stalls new commands.
module lcd_control_status_registers_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  lcdsr_pkg::cmd_t cmd,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output lcdsr_pkg::rsp_t rsp
);

    logic            item_valid;
    lcdsr_pkg::cmd_t item;
    lcdsr_pkg::rsp_t result;
    logic            free;
    logic            exec;

    assign exec = item_valid && free;

    lcdsr_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd),
        .take       (free),
        .item_valid (item_valid),
        .item       (item)
    );

    lcdsr_regfile u_regfile (
        .clk    (clk),
        .rst_n  (rst_n),
        .exec   (exec),
        .item   (item),
        .result (result)
    );

    lcdsr_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (exec),
        .result    (result),
        .free      (free),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
